// ===== rtl/tli_pkg.sv =====
// Shared types, codes and defaults of the tape language interpreter.
package tli_pkg;

  // Default store sizes
  localparam int PROG_DEPTH_DEF = 4096;
  localparam int TAPE_DEPTH_DEF = 32768;

  // Item commands
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_STEP    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Run status codes
  localparam logic [1:0] ST_RUN     = 2'd0;
  localparam logic [1:0] ST_END     = 2'd1;
  localparam logic [1:0] ST_BRACKET = 2'd2;

  // Program characters
  localparam logic [7:0] OP_END   = 8'h00;
  localparam logic [7:0] OP_RIGHT = 8'h3E;
  localparam logic [7:0] OP_LEFT  = 8'h3C;
  localparam logic [7:0] OP_INC   = 8'h2B;
  localparam logic [7:0] OP_DEC   = 8'h2D;
  localparam logic [7:0] OP_OUT   = 8'h2E;
  localparam logic [7:0] OP_IN    = 8'h2C;
  localparam logic [7:0] OP_OPEN  = 8'h5B;
  localparam logic [7:0] OP_CLOSE = 8'h5D;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] prog_addr;
    logic [7:0]  prog_byte;
    logic [7:0]  in_byte;
  } in_item_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        input_taken;
    logic [1:0]  run_status;
    logic [11:0] next_pc;
  } out_item_t;

endpackage

// ===== rtl/tape_language_interpreter.sv =====
// Top level of the tape language interpreter: sequencer, program store and tape.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------
//  in_     | into      | in_valid / in_stall      | in_data  (in_item_t)
//  out_    | out of    | out_valid / out_stall    | out_data (out_item_t)
//
// A plain step passes through accept (with program and tape read), execute and emit.
// A bracket scan adds a read and a check state per program byte walked (program store read port).
// A load subtracts PROG_DEPTH from prog_addr until it lies in the store, then writes and emits.
// A restart clears the tape at one cell a cycle, then emits.
// After reset the same clearing pass runs, with in_stall high.
// A stalled result waits in the output register; the next item is still taken.
module tape_language_interpreter #(
  parameter int PROG_DEPTH = tli_pkg::PROG_DEPTH_DEF,
  parameter int TAPE_DEPTH = tli_pkg::TAPE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tli_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tli_pkg::out_item_t out_data
);

  localparam int PCW = $clog2(PROG_DEPTH);
  localparam int TW  = $clog2(TAPE_DEPTH);
  localparam int DW  = PCW + 1;
  localparam logic [PCW-1:0] PC_LAST = PCW'(PROG_DEPTH - 1);
  localparam logic [TW-1:0]  TP_LAST = TW'(TAPE_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_EXEC, S_FWD_RD, S_FWD_CHK, S_BWD_RD, S_BWD_CHK, S_CLEAR, S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [PCW-1:0]     pc_r, pc_nxt;
  logic [TW-1:0]      dp_r, dp_nxt;
  logic [1:0]         halt_r, halt_nxt;
  logic               ovld_r, ovld_nxt;
  logic               clr_emit_r, clr_emit_nxt;
  logic [TW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [PCW-1:0]     scan_addr_r, scan_addr_nxt;
  logic [DW-1:0]      depth_r, depth_nxt;
  tli_pkg::in_item_t  item_r, item_nxt;
  logic [11:0]        addr_r, addr_nxt;
  logic               fl_out_r, fl_out_nxt;
  logic [7:0]         fl_byte_r, fl_byte_nxt;
  logic               fl_taken_r, fl_taken_nxt;
  tli_pkg::out_item_t out_r, out_nxt;

  logic           prog_we;
  logic [PCW-1:0] prog_waddr, prog_raddr;
  logic [7:0]     prog_rd;
  logic           tape_we;
  logic [TW-1:0]  tape_waddr;
  logic [7:0]     tape_wdata, tape_rd;
  logic           accept;
  logic [DW-1:0]  depth_fwd, depth_bwd;

  // Program store: written by loads, read at pc or at the scan address
  tli_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog (
    .clk     (clk),
    .wr_en   (prog_we),
    .wr_addr (prog_waddr),
    .wr_data (item_r.prog_byte),
    .rd_addr (prog_raddr),
    .rd_data (prog_rd)
  );

  // Tape: read at the data pointer, written by the step or the clearing pass
  tli_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk     (clk),
    .wr_en   (tape_we),
    .wr_addr (tape_waddr),
    .wr_data (tape_wdata),
    .rd_addr (dp_r),
    .rd_data (tape_rd)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = ovld_r;
  assign out_data  = out_r;

  assign prog_raddr = (state_r == S_FWD_RD || state_r == S_BWD_RD) ? scan_addr_r : pc_r;
  assign prog_waddr = PCW'(addr_r);

  // Nesting depth after the scanned byte, one count per direction
  assign depth_fwd = (prog_rd == tli_pkg::OP_OPEN)  ? depth_r + DW'(1) :
                     (prog_rd == tli_pkg::OP_CLOSE) ? depth_r - DW'(1) : depth_r;
  assign depth_bwd = (prog_rd == tli_pkg::OP_OPEN)  ? depth_r - DW'(1) :
                     (prog_rd == tli_pkg::OP_CLOSE) ? depth_r + DW'(1) : depth_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    dp_nxt        = dp_r;
    halt_nxt      = halt_r;
    ovld_nxt      = ovld_r && out_stall;
    clr_emit_nxt  = clr_emit_r;
    clr_addr_nxt  = clr_addr_r;
    scan_addr_nxt = scan_addr_r;
    depth_nxt     = depth_r;
    item_nxt      = item_r;
    addr_nxt      = addr_r;
    fl_out_nxt    = fl_out_r;
    fl_byte_nxt   = fl_byte_r;
    fl_taken_nxt  = fl_taken_r;
    out_nxt       = out_r;
    prog_we       = 1'b0;
    tape_we       = 1'b0;
    tape_waddr    = dp_r;
    tape_wdata    = 8'd0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt     = in_data;
          addr_nxt     = in_data.prog_addr;
          fl_out_nxt   = 1'b0;
          fl_byte_nxt  = 8'd0;
          fl_taken_nxt = 1'b0;
          if (in_data.cmd == tli_pkg::CMD_LOAD) begin
            state_nxt = S_LOAD;
          end else if (in_data.cmd == tli_pkg::CMD_RESTART) begin
            pc_nxt       = '0;
            dp_nxt       = '0;
            halt_nxt     = tli_pkg::ST_RUN;
            clr_addr_nxt = '0;
            clr_emit_nxt = 1'b1;
            state_nxt    = S_CLEAR;
          end else if (in_data.cmd == tli_pkg::CMD_STEP && halt_r == tli_pkg::ST_RUN) begin
            state_nxt = S_EXEC;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end

      S_LOAD: begin
        // Reduce the address modulo the store depth, then write
        if (32'(addr_r) >= PROG_DEPTH) begin
          addr_nxt = addr_r - 12'(PROG_DEPTH);
        end else begin
          prog_we   = 1'b1;
          state_nxt = S_EMIT;
        end
      end

      S_EXEC: begin
        state_nxt = S_EMIT;
        if (prog_rd == tli_pkg::OP_END) begin
          halt_nxt = tli_pkg::ST_END;
        end else if (prog_rd == tli_pkg::OP_OPEN && tape_rd == 8'd0) begin
          // Skip forward to the matching close
          depth_nxt = DW'(1);
          if (pc_r == PC_LAST) begin
            halt_nxt = tli_pkg::ST_BRACKET;
          end else begin
            scan_addr_nxt = pc_r + PCW'(1);
            state_nxt     = S_FWD_RD;
          end
        end else if (prog_rd == tli_pkg::OP_CLOSE) begin
          // Walk back to the matching open
          depth_nxt = DW'(1);
          if (pc_r == '0) begin
            halt_nxt = tli_pkg::ST_BRACKET;
          end else begin
            scan_addr_nxt = pc_r - PCW'(1);
            state_nxt     = S_BWD_RD;
          end
        end else begin
          case (prog_rd)
            tli_pkg::OP_RIGHT: dp_nxt = (dp_r == TP_LAST) ? '0 : dp_r + TW'(1);
            tli_pkg::OP_LEFT:  dp_nxt = (dp_r == '0) ? TP_LAST : dp_r - TW'(1);
            tli_pkg::OP_INC: begin
              tape_we    = 1'b1;
              tape_wdata = tape_rd + 8'd1;
            end
            tli_pkg::OP_DEC: begin
              tape_we    = 1'b1;
              tape_wdata = tape_rd - 8'd1;
            end
            tli_pkg::OP_OUT: begin
              fl_out_nxt  = 1'b1;
              fl_byte_nxt = tape_rd;
            end
            tli_pkg::OP_IN: begin
              tape_we      = 1'b1;
              tape_wdata   = item_r.in_byte;
              fl_taken_nxt = 1'b1;
            end
            default: ;
          endcase
          // Advance pc, or halt at the end of the store
          if (pc_r == PC_LAST) begin
            halt_nxt = tli_pkg::ST_END;
          end else begin
            pc_nxt = pc_r + PCW'(1);
          end
        end
      end

      S_FWD_RD: state_nxt = S_FWD_CHK;

      S_FWD_CHK: begin
        if (prog_rd == tli_pkg::OP_END) begin
          halt_nxt  = tli_pkg::ST_BRACKET;
          state_nxt = S_EMIT;
        end else if (depth_fwd == '0) begin
          if (scan_addr_r == PC_LAST) begin
            pc_nxt   = scan_addr_r;
            halt_nxt = tli_pkg::ST_END;
          end else begin
            pc_nxt = scan_addr_r + PCW'(1);
          end
          state_nxt = S_EMIT;
        end else if (scan_addr_r == PC_LAST) begin
          halt_nxt  = tli_pkg::ST_BRACKET;
          state_nxt = S_EMIT;
        end else begin
          scan_addr_nxt = scan_addr_r + PCW'(1);
          depth_nxt     = depth_fwd;
          state_nxt     = S_FWD_RD;
        end
      end

      S_BWD_RD: state_nxt = S_BWD_CHK;

      S_BWD_CHK: begin
        if (depth_bwd == '0) begin
          pc_nxt    = scan_addr_r;
          state_nxt = S_EMIT;
        end else if (scan_addr_r == '0) begin
          halt_nxt  = tli_pkg::ST_BRACKET;
          state_nxt = S_EMIT;
        end else begin
          scan_addr_nxt = scan_addr_r - PCW'(1);
          depth_nxt     = depth_bwd;
          state_nxt     = S_BWD_RD;
        end
      end

      S_CLEAR: begin
        // Zero one cell a cycle
        tape_we    = 1'b1;
        tape_waddr = clr_addr_r;
        if (clr_addr_r == TP_LAST) begin
          state_nxt = clr_emit_r ? S_EMIT : S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + TW'(1);
        end
      end

      S_EMIT: begin
        // Load the output register once it is free
        if (!ovld_r || !out_stall) begin
          out_nxt.out_valid   = fl_out_r;
          out_nxt.out_byte    = fl_byte_r;
          out_nxt.input_taken = fl_taken_r;
          out_nxt.run_status  = halt_r;
          out_nxt.next_pc     = 12'(pc_r);
          ovld_nxt            = 1'b1;
          state_nxt           = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      pc_r       <= '0;
      dp_r       <= '0;
      halt_r     <= tli_pkg::ST_RUN;
      ovld_r     <= 1'b0;
      clr_emit_r <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      pc_r       <= pc_nxt;
      dp_r       <= dp_nxt;
      halt_r     <= halt_nxt;
      ovld_r     <= ovld_nxt;
      clr_emit_r <= clr_emit_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
    scan_addr_r <= scan_addr_nxt;
    depth_r     <= depth_nxt;
    item_r      <= item_nxt;
    addr_r      <= addr_nxt;
    fl_out_r    <= fl_out_nxt;
    fl_byte_r   <= fl_byte_nxt;
    fl_taken_r  <= fl_taken_nxt;
    out_r       <= out_nxt;
  end

endmodule

// ===== rtl/tli_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/tli_checker.sv =====
// Port-level checker of the tape language interpreter and its bind.
module tli_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input tli_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input tli_pkg::out_item_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // One item at a time: stall follows every accepted item
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while busy");

  // The clearing pass after reset holds off items
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("item taken during the clearing pass");

  // A step emits or takes a byte, never both
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.out_valid && out_data.input_taken))
    else $error("emit and input in one item");

  // No emitted byte means a zero byte field
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.out_valid |-> out_data.out_byte == 8'd0)
    else $error("byte field set without emit");

endmodule

bind tape_language_interpreter tli_checker u_tli_checker (.*);
